FILE: design/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared constants, types and state codes of the moving average block.
// ----------------------------------------------------------------------------
package mavg_pkg;

    // sizes of the sample path and the delay line
    localparam int SAMPLE_BITS = 32;
    localparam int MAX_WINDOW  = 1024;
    localparam int ADDR_W      = $clog2(MAX_WINDOW);
    localparam int WIN_W       = ADDR_W + 1;
    localparam int SUM_W       = SAMPLE_BITS + ADDR_W;
    localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

    // window length after reset
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(100);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } mavg_state_t;

    // divider status seen by the sequencer
    typedef struct packed {
        logic                   done;
        logic                   negative;
        logic [SAMPLE_BITS-1:0] quotient;
    } div_result_t;

endpackage

FILE: design/moving_average_warmup.sv
// ----------------------------------------------------------------------------
// moving_average_warmup
// Boxcar moving average with warm-up over signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Each accepted sample beat yields one average beat, the mean of the last
// min(samples seen, window) samples truncated toward zero. After acceptance
// a sample passes through the running-sum update, which uses the leaving
// sample read at acceptance, the divider load, the bit-serial divider
// (one quotient bit per cycle over the 42-bit sum), the register of its done
// flag and the move of the result into the output register, which waits
// while a stalled average still holds that register. The next sample is
// taken in the cycle after that, so no new sample enters before the last
// average is loaded, though that average may still wait for the output.
// A window of zero acts as one and a window above 1024 acts as 1024; writing
// the window restarts averaging. The delay line needs no clearing after reset.
// ----------------------------------------------------------------------------
module moving_average_warmup
    import mavg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [WIN_W-1:0]              cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          start_of_sequence,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] average
);

    mavg_state_t             state_reg, state_next;
    logic [WIN_W-1:0]        window_reg;
    logic [WIN_W-1:0]        win_eff;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [WIN_W-1:0]        seen_reg, seen_next;
    logic [ADDR_W-1:0]       write_slot_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic                    sos_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_BITS-1:0]  average_reg;

    logic                    in_accept;
    logic                    out_slot_free;
    logic                    ram_re;
    logic                    ram_we;
    logic                    div_start;
    logic                    load_out;
    logic [ADDR_W-1:0]       old_slot;
    logic [SAMPLE_BITS-1:0]  old_sample;
    logic signed [SUM_W-1:0] sum_base;
    logic [WIN_W-1:0]        seen_base;
    logic                    full;
    div_result_t             div_res;

    // window clamped to the legal range
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (window_reg > WIN_W'(MAX_WINDOW))
        begin
            win_eff = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = window_reg;
        end
    end

    assign in_accept     = in_valid && !in_stall;
    assign out_slot_free = !out_valid_reg || !out_stall;

    // slot of the sample leaving the window, read before the new write
    assign old_slot = write_slot_reg - win_eff[ADDR_W-1:0];

    // running-sum update with start-of-sequence clear
    always_comb
    begin
        sum_base  = sos_reg ? '0 : sum_reg;
        seen_base = sos_reg ? '0 : seen_reg;
        full      = seen_base >= win_eff;
        sum_next  = sum_base + SUM_W'(signed'(sample_reg));
        if (full)
        begin
            sum_next  = sum_next - SUM_W'(signed'(old_sample));
            seen_next = win_eff;
        end
        else
        begin
            seen_next = seen_base + 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = 1'b1;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                ram_re   = in_valid;
            end
            ST_SUM:  ram_we    = 1'b1;
            ST_LOAD: div_start = 1'b1;
            ST_DIV:  ;
            ST_DONE: load_out  = out_slot_free;
            default: ;
        endcase
    end

    // control state and running totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_reg     <= WIN_RESET;
            sum_reg        <= '0;
            seen_reg       <= '0;
            write_slot_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SUM)
            begin
                sum_reg        <= sum_next;
                seen_reg       <= seen_next;
                write_slot_reg <= write_slot_reg + 1'b1;
            end
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
                sum_reg    <= '0;
                seen_reg   <= '0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample;
            sos_reg    <= start_of_sequence;
        end
        if (load_out)
        begin
            average_reg <= div_res.negative ? (~div_res.quotient + 1'b1)
                                            : div_res.quotient;
        end
    end

    // delay line
    mavg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_delay (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_slot_reg),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (old_slot),
        .rdata (old_sample)
    );

    // divider
    mavg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (seen_reg),
        .result   (div_res)
    );

    assign out_valid = out_valid_reg;
    assign average   = average_reg;

    // count never exceeds the window in force
    a_seen_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= win_eff)
        else $error("samples seen above window");

    // an accepted beat always goes straight to the sum update
    a_accept_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_SUM)
        else $error("accepted beat did not reach sum update");

    // divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == ST_DIV)
        else $error("divider done outside divide state");

    // the write slot moves once per sample
    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM |=> write_slot_reg == $past(write_slot_reg) + 1'b1)
        else $error("write slot did not advance");

    // a new average beat appears only from the done state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("average beat without finished division");

endmodule

FILE: design/mavg_ram.sv
// ----------------------------------------------------------------------------
// mavg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mavg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/mavg_div.sv
// ----------------------------------------------------------------------------
// mavg_div
// Bit-serial restoring divider: signed running sum by an unsigned window
// count, one quotient bit per cycle, result truncated toward zero.
// ----------------------------------------------------------------------------
module mavg_div
    import mavg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [WIN_W-1:0]        divisor,
    output div_result_t             result
);

    logic [SUM_W-1:0]     dvd_reg, dvd_next;
    logic [WIN_W-2:0]     rem_reg, rem_next;
    logic [WIN_W-1:0]     dvs_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WIN_W-1:0]     rem_shift;
    logic [WIN_W:0]       trial;
    logic                 fits;

    // one restoring step: shift in the next dividend bit, try a subtract
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[SUM_W-1]};
        trial     = {1'b0, rem_shift} - {1'b0, dvs_reg};
        fits      = !trial[WIN_W];
    end

    // next values of the shift registers and the bit counter
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[SUM_W-2:0], fits};
            rem_next = fits ? trial[WIN_W-2:0] : rem_shift[WIN_W-2:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
    end

    assign result.done     = done_reg;
    assign result.negative = neg_reg;
    assign result.quotient = dvd_reg[SAMPLE_BITS-1:0];

endmodule

FILE: sim/moving_average_warmup_tb.sv
// ----------------------------------------------------------------------------
// moving_average_warmup_tb
// Self-checking bench for the boxcar moving average with warm-up.
// ----------------------------------------------------------------------------
// Sample beats are queued by the main sequence and sent by a clocked driver
// that inserts random gaps. Each accepted beat runs through a local model
// of the running sum, delay line and warm-up count. That model yields the
// average the block should return. A clocked monitor stalls the output at
// random and compares every average beat with the oldest pending value. The
// window is rewritten between phases only while the block is idle. The
// phases cover the reset window, zero, one, two, small random windows, 1024 and
// the clamp above 1024.
// ----------------------------------------------------------------------------
module moving_average_warmup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mavg_pkg::*;

    localparam longint LIMIT_CYCLES = 3_000_000;
    localparam int     DRAIN_CYCLES = 60;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // bias of sample values within a phase
    typedef enum int {
        MIX_RANDOM,
        MIX_HIGH,
        MIX_LOW
    } sample_mix_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          restart;
    } sample_beat_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [WIN_W-1:0]              cfg_wdata = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] sample = '0;
    logic                          start_of_sequence = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] average;

    sample_beat_t           pending_q[$];
    logic [SAMPLE_BITS-1:0] average_q[$];
    sample_beat_t           next_beat;
    logic [SAMPLE_BITS-1:0] want_avg;

    // model state: delay line, running sum, warm-up count, write slot, window
    longint           win_delay[MAX_WINDOW];
    longint           win_sum = 0;
    int               win_count = 0;
    int               win_slot = 0;
    logic [WIN_W-1:0] win_length = WIN_RESET;

    int     errors = 0;
    int     beats_in = 0;
    int     beats_out = 0;
    int     windows_used = 1;
    int     gap_left = 0;
    int     stall_left = 0;
    int     stall_len = 0;
    longint cycle_count = 0;
    bit     calm = 1'b0;

    moving_average_warmup dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample            (sample),
        .start_of_sequence (start_of_sequence),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .average           (average)
    );

    initial forever #5 clk = ~clk;

    task automatic flag_error(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // expected average for one accepted sample, updates the model state
    function automatic logic [SAMPLE_BITS-1:0] next_average(
        input logic signed [SAMPLE_BITS-1:0] value,
        input logic                          restart
    );
        int     span;
        int     oldest;
        longint quotient;
        span = (win_length == 0) ? 1 :
               (win_length > MAX_WINDOW) ? MAX_WINDOW : int'(win_length);
        if (restart)
        begin
            win_sum   = 0;
            win_count = 0;
        end
        win_sum += longint'(value);
        if (win_count >= span)
        begin
            // full window: the leaving sample sits span slots behind the write slot
            oldest    = (win_slot + MAX_WINDOW - span) % MAX_WINDOW;
            win_sum  -= win_delay[oldest];
            win_count = span;
            quotient  = win_sum / span;
        end
        else
        begin
            win_count++;
            quotient = win_sum / win_count;
        end
        win_delay[win_slot] = longint'(value);
        win_slot = (win_slot + 1) % MAX_WINDOW;
        return quotient[SAMPLE_BITS-1:0];
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(80, 10);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input sample_mix_t mix);
        int roll;
        roll = $urandom_range(99);
        if (mix == MIX_HIGH && roll < 90)
            return SAMPLE_MAX;
        if (mix == MIX_LOW && roll < 90)
            return SAMPLE_MIN;
        if (roll < 8)
            return SAMPLE_MAX;
        if (roll < 16)
            return SAMPLE_MIN;
        if (roll < 40)
            return SAMPLE_BITS'(int'($urandom_range(2000)) - 1000);
        return SAMPLE_BITS'($urandom());
    endfunction

    task automatic add_beat(input logic signed [SAMPLE_BITS-1:0] value, input logic restart);
        sample_beat_t beat;
        beat.value   = value;
        beat.restart = restart;
        pending_q.push_back(beat);
    endtask

    // checked between edges so that the driver's queue pop has settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || in_valid || average_q.size() != 0);
    endtask

    // window write, only issued while the block is idle
    task automatic write_window(input int len);
        @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= WIN_W'(len);
        win_length  = WIN_W'(len);
        win_sum     = 0;
        win_count   = 0;
        windows_used++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(
        input int  len,
        input int  beats,
        input int  restart_pct,
        input bit  swing
    );
        sample_mix_t mix;
        write_window(len);
        for (int i = 0; i < beats; i++)
        begin
            mix = swing ? sample_mix_t'((i / 128) % 3) : MIX_RANDOM;
            add_beat(pick_sample(mix), $urandom_range(99) < restart_pct);
        end
        wait_idle();
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid          <= 1'b0;
            sample            <= '0;
            start_of_sequence <= 1'b0;
            gap_left           = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                average_q.push_back(next_average(sample, start_of_sequence));
                beats_in++;
            end
            // a stalled beat holds its payload
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (pending_q.size() != 0)
                begin
                    next_beat          = pending_q.pop_front();
                    in_valid          <= 1'b1;
                    sample            <= next_beat.value;
                    start_of_sequence <= next_beat.restart;
                    gap_left           = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // average monitor with random output stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_out++;
                if (average_q.size() == 0)
                begin
                    flag_error($sformatf("average %h arrived with nothing pending", average));
                end
                else
                begin
                    want_avg = average_q.pop_front();
                    if (average !== want_avg)
                        flag_error($sformatf("average %h, expected %h", average, want_avg));
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                stall_len  = pick_gap();
                out_stall <= (stall_len != 0);
                stall_left = (stall_len > 0) ? stall_len - 1 : 0;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("run limit reached after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset window of 100: extremes, start flag, truncation toward zero
        add_beat(SAMPLE_MAX, 1'b1);
        add_beat(SAMPLE_MAX, 1'b0);
        add_beat(SAMPLE_MIN, 1'b0);
        add_beat(SAMPLE_MIN, 1'b0);
        add_beat(SAMPLE_BITS'(-1), 1'b0);
        add_beat(SAMPLE_BITS'(1), 1'b0);
        add_beat('0, 1'b0);
        add_beat(SAMPLE_BITS'(-3), 1'b1);
        add_beat('0, 1'b0);
        add_beat(SAMPLE_BITS'(1), 1'b0);
        add_beat(SAMPLE_BITS'(-7), 1'b0);
        add_beat(SAMPLE_MAX, 1'b1);
        add_beat(SAMPLE_BITS'(1), 1'b0);
        add_beat(SAMPLE_MIN, 1'b1);
        add_beat(SAMPLE_BITS'(-1), 1'b0);
        wait_idle();

        // window of two with the sum at both extremes
        write_window(2);
        add_beat(SAMPLE_MAX, 1'b1);
        add_beat(SAMPLE_MAX, 1'b0);
        add_beat(SAMPLE_MAX, 1'b0);
        add_beat(SAMPLE_MIN, 1'b0);
        add_beat(SAMPLE_MIN, 1'b0);
        add_beat(SAMPLE_MIN, 1'b0);
        add_beat(SAMPLE_MAX, 1'b0);
        add_beat(SAMPLE_BITS'(-1), 1'b0);
        wait_idle();

        // zero acts as one, then one itself
        run_phase(0, 40, 3, 1'b0);
        run_phase(1, 30, 5, 1'b0);

        // above the limit clamps to 1024, run back to back
        calm = 1'b1;
        run_phase((1 << WIN_W) - 1, 60, 0, 1'b0);
        calm = 1'b0;

        // longest window, well past warm-up, sum swinging to both extremes
        run_phase(MAX_WINDOW, 1100, 0, 1'b1);

        // short random windows with occasional restarts
        for (int p = 0; p < 8; p++)
            run_phase($urandom_range(40, 3), 50, 4, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d samples, checked %0d averages across %0d window settings",
                 beats_in, beats_out, windows_used);
        $display("windows from 0 to 2047, restarts mid-stream, sums at both extremes");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
